// ----- rtl/hbf_pkg.sv -----
`timescale 1ns / 1ps
package hbf_pkg;

	localparam int NOW_BITS      = 32;
	localparam int CFG_BITS      = 32;
	localparam int KIND_BITS     = 2;
	localparam int PHASE_BITS    = 3;
	localparam int CFG_IDX_BITS  = 2;
	localparam int TIME_BITS_DEF = 32;

	localparam logic [CFG_BITS-1:0] HELLO_INTERVAL_RST  = 32'd1000;
	localparam logic [CFG_BITS-1:0] READY_INTERVAL_RST  = 32'd1000;
	localparam logic [CFG_BITS-1:0] OVERALL_TIMEOUT_RST = 32'd10000;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_START    = 2'd0,
		KIND_TICK     = 2'd1,
		KIND_HELLO    = 2'd2,
		KIND_RT_START = 2'd3
	} kind_t;

	typedef enum logic [PHASE_BITS-1:0] {
		PH_INIT       = 3'd0,
		PH_WAIT_HELLO = 3'd1,
		PH_WAIT_START = 3'd2,
		PH_READY      = 3'd3,
		PH_RUNNING    = 3'd4,
		PH_FAILED     = 3'd5
	} phase_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_HELLO_INTERVAL  = 2'd0,
		REG_READY_INTERVAL  = 2'd1,
		REG_OVERALL_TIMEOUT = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] hello_interval;
		logic [CFG_BITS-1:0] ready_interval;
		logic [CFG_BITS-1:0] overall_timeout;
	} cfg_t;

	typedef struct packed {
		logic                  send_client_hello;
		logic                  send_runtime_ready;
		logic [PHASE_BITS-1:0] phase;
		logic                  is_ready;
	} res_t;

endpackage

// ----- rtl/hbf_item_if.sv -----
`timescale 1ns / 1ps
interface hbf_item_if;
	import hbf_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [KIND_BITS-1:0] kind;
	logic [NOW_BITS-1:0]  now_time;
	logic                 payload_present;

	modport source (output valid, output kind, output now_time, output payload_present,
		input ready);
	modport sink (input valid, input kind, input now_time, input payload_present,
		output ready);
endinterface

// ----- rtl/hbf_result_if.sv -----
`timescale 1ns / 1ps
interface hbf_result_if;
	import hbf_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  send_client_hello;
	logic                  send_runtime_ready;
	logic [PHASE_BITS-1:0] phase;
	logic                  is_ready;

	modport source (output valid, output send_client_hello, output send_runtime_ready,
		output phase, output is_ready, input ready);
	modport sink (input valid, input send_client_hello, input send_runtime_ready,
		input phase, input is_ready, output ready);
endinterface

// ----- rtl/hbf_cfg_if.sv -----
`timescale 1ns / 1ps
interface hbf_cfg_if;
	import hbf_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [CFG_IDX_BITS-1:0] index;
	logic [CFG_BITS-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/hbf_cfg_regs.sv -----
`timescale 1ns / 1ps
module hbf_cfg_regs (
	input  logic         clk,
	input  logic         arst_n,
	hbf_cfg_if.sink      cfg,
	output hbf_pkg::cfg_t regs
);
	import hbf_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	// drop writes to indexes past the last register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.hello_interval  <= HELLO_INTERVAL_RST;
			regs_q.ready_interval  <= READY_INTERVAL_RST;
			regs_q.overall_timeout <= OVERALL_TIMEOUT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_HELLO_INTERVAL:  regs_q.hello_interval  <= cfg.data;
				REG_READY_INTERVAL:  regs_q.ready_interval  <= cfg.data;
				REG_OVERALL_TIMEOUT: regs_q.overall_timeout <= cfg.data;
				default: ;
			endcase
		end
	end
endmodule

// ----- rtl/hbf_core.sv -----
`timescale 1ns / 1ps
module hbf_core #(
	parameter int TIME_BITS = hbf_pkg::TIME_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  hbf_pkg::kind_t               kind,
	input  logic [hbf_pkg::NOW_BITS-1:0] now_time,
	input  logic                         present,
	input  hbf_pkg::cfg_t                cfg,
	output hbf_pkg::res_t                res
);
	import hbf_pkg::*;

	localparam int CMP_BITS = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;

	phase_t               phase_q, nxt_phase;
	logic [TIME_BITS-1:0] started_q, last_hello_q, last_ready_q;
	logic [TIME_BITS-1:0] nxt_started, nxt_hello_at, nxt_ready_at;
	logic [CMP_BITS-1:0]  now_ext;
	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] el_start, el_hello, el_ready;
	logic                 timeout, hello_due, ready_due;
	logic                 send_hello, send_ready;

	// widen or cut the timestamp to the time base; differences wrap at its width
	assign now_ext   = CMP_BITS'(now_time);
	assign now_t     = now_ext[TIME_BITS-1:0];
	assign el_start  = now_t - started_q;
	assign el_hello  = now_t - last_hello_q;
	assign el_ready  = now_t - last_ready_q;
	assign timeout   = CMP_BITS'(el_start) >= CMP_BITS'(cfg.overall_timeout);
	assign hello_due = CMP_BITS'(el_hello) >= CMP_BITS'(cfg.hello_interval);
	assign ready_due = CMP_BITS'(el_ready) >= CMP_BITS'(cfg.ready_interval);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_INIT;
			started_q    <= '0;
			last_hello_q <= '0;
			last_ready_q <= '0;
		end else if (step) begin
			phase_q      <= nxt_phase;
			started_q    <= nxt_started;
			last_hello_q <= nxt_hello_at;
			last_ready_q <= nxt_ready_at;
		end
	end

	always_comb begin
		nxt_phase    = phase_q;
		nxt_started  = started_q;
		nxt_hello_at = last_hello_q;
		nxt_ready_at = last_ready_q;
		send_hello   = 1'b0;
		send_ready   = 1'b0;
		unique case (kind)
			KIND_START: begin
				nxt_phase    = PH_INIT;
				nxt_started  = now_t;
				nxt_hello_at = '0;
				nxt_ready_at = '0;
			end
			KIND_TICK: begin
				unique case (phase_q)
					PH_INIT: begin
						if (timeout) begin
							nxt_phase = PH_FAILED;
						end else begin
							nxt_phase    = PH_WAIT_HELLO;
							nxt_hello_at = now_t;
							send_hello   = 1'b1;
						end
					end
					PH_WAIT_HELLO: begin
						if (timeout) begin
							nxt_phase = PH_FAILED;
						end else if (hello_due) begin
							nxt_hello_at = now_t;
							send_hello   = 1'b1;
						end
					end
					PH_WAIT_START: begin
						if (timeout) begin
							nxt_phase = PH_FAILED;
						end else if (ready_due) begin
							nxt_ready_at = now_t;
							send_ready   = 1'b1;
						end
					end
					PH_READY: nxt_phase = PH_RUNNING;
					default: ;
				endcase
			end
			KIND_HELLO: begin
				if (present && phase_q == PH_WAIT_HELLO) begin
					nxt_phase    = PH_WAIT_START;
					nxt_ready_at = now_t;
					send_ready   = 1'b1;
				end
			end
			KIND_RT_START: begin
				if (present && phase_q == PH_WAIT_START) begin
					nxt_phase = PH_READY;
				end
			end
			default: ;
		endcase
		res.send_client_hello  = send_hello;
		res.send_runtime_ready = send_ready;
		res.phase              = nxt_phase;
		res.is_ready           = (nxt_phase == PH_RUNNING);
	end

	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(phase_q) && $stable(started_q))
		else $error("state moved without an item");

	a_start_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		step && kind == KIND_START |=> phase_q == PH_INIT && last_hello_q == '0
			&& last_ready_q == '0)
		else $error("start did not restart the handshake");

	a_failed_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_FAILED && kind != KIND_START |=> phase_q == PH_FAILED)
		else $error("left failed without a start");
endmodule

// ----- rtl/handshake_bringup_fsm.sv -----
`timescale 1ns / 1ps
// Bring-up handshake sequencer. Each word on req carries a kind (start, tick, server
// hello, runtime start), a millisecond timestamp and a present flag; for every word
// exactly one word comes back on rsp with the two send requests and the phase after
// that word. The block takes one word per clock cycle when rsp is drained, and a word
// passes through the input register and then the result register, with all decisions
// made by a single pass of compare logic between them. Throughput is set by the result
// register: while a result waits, one more word is held in the input register, then req
// stalls. Interval and timeout registers are written on cfg, which is always ready;
// write them only when no word is in flight. Time differences wrap at TIME_BITS bits.
module handshake_bringup_fsm #(
	parameter int TIME_BITS = hbf_pkg::TIME_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	hbf_item_if.sink    req,
	hbf_result_if.source rsp,
	hbf_cfg_if.sink     cfg
);
	import hbf_pkg::*;

	// input register
	logic                valid_s1;
	kind_t               kind_s1;
	logic [NOW_BITS-1:0] now_s1;
	logic                present_s1;

	// result register
	logic valid_s2;
	res_t res_s2;

	cfg_t regs;
	res_t res;
	logic advance;

	hbf_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// advance the held word when the result slot is free or being drained this cycle
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// payload needs no reset; load it only with a new word
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			kind_s1    <= kind_t'(req.kind);
			now_s1     <= req.now_time;
			present_s1 <= req.payload_present;
		end
	end

	// state update and result decision happen together on advance
	hbf_core #(
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.kind     (kind_s1),
		.now_time (now_s1),
		.present  (present_s1),
		.cfg      (regs),
		.res      (res)
	);

	// hold the result until the sink takes it; drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign rsp.valid              = valid_s2;
	assign rsp.send_client_hello  = res_s2.send_client_hello;
	assign rsp.send_runtime_ready = res_s2.send_runtime_ready;
	assign rsp.phase              = res_s2.phase;
	assign rsp.is_ready           = res_s2.is_ready;

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(kind_s1) && $stable(now_s1)
			&& $stable(present_s1))
		else $error("held word lost or changed");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("advanced word produced no result");

	a_one_send: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> !(res_s2.send_client_hello && res_s2.send_runtime_ready))
		else $error("both send requests raised for one word");
endmodule
